>>> src/convex_region_point_test_top_assert.svh
// Assertion macros for the convex region point test block.
// Included by the checker; no other dependencies.
`ifndef CONVEX_REGION_POINT_TEST_TOP_ASSERT_SVH
`define CONVEX_REGION_POINT_TEST_TOP_ASSERT_SVH

// same-cycle implication
`define CRPT_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CRPT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/crpt_pkg.sv
// Shared constants, codes and control structs for the convex region point test.
// No dependencies; used by every module of the block.
package crpt_pkg;

    localparam int MAX_PLANES_DEF  = 16;
    localparam int COORD_WIDTH_DEF = 32;

    localparam int PIDX_W    = 4;    // plane_index field
    localparam int COEF_W    = 32;   // a, b, c, x, y, z fields
    localparam int OFFSET_W  = 64;   // d field
    localparam int PCOUNT_W  = 5;    // plane_count register
    localparam int SUM_W     = 66;   // exact sum of three products and d

    // s_tdata layout, lowest bit first
    localparam int PIDX_LSB  = 0;
    localparam int A_LSB     = PIDX_LSB + PIDX_W;
    localparam int B_LSB     = A_LSB + COEF_W;
    localparam int C_LSB     = B_LSB + COEF_W;
    localparam int D_LSB     = C_LSB + COEF_W;
    localparam int X_LSB     = D_LSB + OFFSET_W;
    localparam int Y_LSB     = X_LSB + COEF_W;
    localparam int Z_LSB     = Y_LSB + COEF_W;
    localparam int S_BITS    = Z_LSB + COEF_W;
    localparam int S_TDATA_W = ((S_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_TEST  = 1'b1;
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TEST = 1'b1;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic valid;
        logic used;
        logic last;
    } evl_tag_t;

    typedef struct packed {
        logic valid;
        logic used;
        logic last;
        logic nonpos;
        logic nonneg;
    } evl_res_t;

endpackage

>>> src/convex_region_point_test_top.sv
// Top level of the convex region point test: plane ring, evaluator, control.
// Depends on crpt_pkg, crpt_cell and crpt_eval.
//
// A load beat (tuser = 0) writes one plane into slot plane_index and is
// acknowledged by one output beat with inside_res = 0 the cycle after it is
// taken. A test beat (tuser = 1) rotates the whole plane ring once past a
// single shared evaluator, one plane per cycle. A test therefore rotates
// every slot past the evaluator, then control waits while the last plane
// passes the three evaluator stages, then the answer is loaded into the
// output register; the whole ring rotates every time, whatever
// plane_count holds. One item is
// worked on at a time; s_tready is high only while idle and the output
// register is free or being emptied. Only slots 0 .. plane_count-1 count
// toward the answer; plane_count above MAX_PLANES acts as MAX_PLANES, and a
// load to a slot at or above MAX_PLANES is acknowledged but stores nothing.
// Coefficients and coordinates are taken from their low COORD_WIDTH bits.
// The answer is inside when every plane in use gives a*x+b*y+c*z+d <= 0, or
// every one gives >= 0; with no planes in use the answer is inside. Slots
// used by a test must have been loaded first. The user must write
// plane_count only while the block is idle; the block does not enforce it.
module convex_region_point_test_top #(
    parameter int MAX_PLANES  = crpt_pkg::MAX_PLANES_DEF,
    parameter int COORD_WIDTH = crpt_pkg::COORD_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // config register
    input  logic                           plane_count_we,
    input  logic [crpt_pkg::PCOUNT_W-1:0]  plane_count_wdata,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // plane_index[3:0], coef_a[35:4], coef_b[67:36], coef_c[99:68],
    // coef_d[163:100], point_x[195:164], point_y[227:196], point_z[259:228]
    input  logic [crpt_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,   // cmd
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [crpt_pkg::M_TDATA_W-1:0] m_tdata,   // inside_res[0]
    output logic                           m_tuser    // answer_kind
);
    import crpt_pkg::*;

    localparam int CW       = COORD_WIDTH;
    localparam int PLANE_W  = 3 * CW + OFFSET_W;
    localparam int IDX_W    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CMP_W    = (IDX_W > PCOUNT_W) ? IDX_W : PCOUNT_W;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_PLANES - 1);

    // control states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;   // ring rotating, issuing planes
    localparam logic [1:0] ST_DRAIN = 2'd2;   // waiting on evaluator
    localparam logic [1:0] ST_DONE  = 2'd3;   // answer ready for output reg

    logic [1:0]             state_reg, state_next;
    logic [IDX_W-1:0]       step_reg, step_next;
    logic [PCOUNT_W-1:0]    plane_count_reg;
    logic                   all_np_reg, all_np_next;
    logic                   all_nn_reg, all_nn_next;
    logic signed [CW-1:0]   x_reg, y_reg, z_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_inside_reg, out_inside_next;
    logic                   out_kind_reg, out_kind_next;

    logic                   in_beat, load_beat, test_beat;
    logic                   out_free;
    logic [PLANE_W-1:0]     load_plane;
    logic [PLANE_W-1:0]     ring [MAX_PLANES];
    cell_ctl_t              cell_ctl [MAX_PLANES];
    evl_tag_t               tag;
    evl_res_t               res;

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_beat   = s_tvalid && s_tready;
    assign load_beat = in_beat && (s_tuser == CMD_LOAD);
    assign test_beat = in_beat && (s_tuser == CMD_TEST);

    // plane as stored in a cell: {d, c, b, a}, coefficients trimmed to CW
    assign load_plane = {s_tdata[D_LSB +: OFFSET_W], s_tdata[C_LSB +: CW],
                         s_tdata[B_LSB +: CW], s_tdata[A_LSB +: CW]};

    // ---- plane ring: cell i takes cell i+1, last cell takes cell 0 ----
    for (genvar i = 0; i < MAX_PLANES; i++)
    begin : g_cell
        assign cell_ctl[i].load  = load_beat &&
                                   (32'(s_tdata[PIDX_LSB +: PIDX_W]) == i);
        assign cell_ctl[i].shift = (state_reg == ST_RUN);

        crpt_cell #(
            .PLANE_W (PLANE_W)
        ) u_cell (
            .clk            (clk),
            .ctl            (cell_ctl[i]),
            .load_plane     (load_plane),
            .neighbor_plane (ring[(i + 1) % MAX_PLANES]),
            .plane          (ring[i])
        );
    end

    // ---- evaluator fed from the head of the ring ----
    assign tag.valid = (state_reg == ST_RUN);
    assign tag.used  = CMP_W'(step_reg) < CMP_W'(plane_count_reg);
    assign tag.last  = (step_reg == LAST_STEP);

    crpt_eval #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .plane_in (ring[0]),
        .px       (x_reg),
        .py       (y_reg),
        .pz       (z_reg),
        .tag_in   (tag),
        .res_out  (res)
    );

    // ---- control ----
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        all_np_next     = all_np_reg;
        all_nn_next     = all_nn_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_inside_next = out_inside_reg;
        out_kind_next   = out_kind_reg;

        // fold each plane in use into the two side flags
        if (res.valid && res.used)
        begin
            all_np_next = all_np_reg && res.nonpos;
            all_nn_next = all_nn_reg && res.nonneg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (load_beat)
                begin
                    out_valid_next  = 1'b1;
                    out_inside_next = 1'b0;
                    out_kind_next   = KIND_LOAD;
                end
                else if (test_beat)
                begin
                    all_np_next = 1'b1;
                    all_nn_next = 1'b1;
                    step_next   = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (res.valid && res.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_inside_next = all_np_reg || all_nn_reg;
                    out_kind_next   = KIND_TEST;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            plane_count_reg <= '0;
            all_np_reg      <= 1'b1;
            all_nn_reg      <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            all_np_reg    <= all_np_next;
            all_nn_reg    <= all_nn_next;
            out_valid_reg <= out_valid_next;
            if (plane_count_we)
            begin
                plane_count_reg <= plane_count_wdata;
            end
        end
    end

    // payload: point and output beat
    always_ff @(posedge clk)
    begin
        if (test_beat)
        begin
            x_reg <= s_tdata[X_LSB +: CW];
            y_reg <= s_tdata[Y_LSB +: CW];
            z_reg <= s_tdata[Z_LSB +: CW];
        end
        out_inside_reg <= out_inside_next;
        out_kind_reg   <= out_kind_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_inside_reg);
    assign m_tuser  = out_kind_reg;

endmodule

>>> src/crpt_cell.sv
// One plane slot of the plane ring: loads a plane or takes its neighbor's.
// Depends on crpt_pkg.
module crpt_cell #(
    parameter int PLANE_W = 160
) (
    input  logic               clk,
    input  crpt_pkg::cell_ctl_t ctl,
    input  logic [PLANE_W-1:0] load_plane,
    input  logic [PLANE_W-1:0] neighbor_plane,
    output logic [PLANE_W-1:0] plane
);
    import crpt_pkg::*;

    logic [PLANE_W-1:0] plane_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            plane_reg <= load_plane;
        end
        else if (ctl.shift)
        begin
            plane_reg <= neighbor_plane;
        end
    end

    assign plane = plane_reg;

endmodule

>>> src/crpt_eval.sv
// Three-stage plane evaluator: a*x, b*y, c*z in parallel, then two adds,
// then the exact sum; its sign and zero are decoded. Depends on crpt_pkg.
module crpt_eval #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [3*COORD_WIDTH+63:0]      plane_in,   // {d, c, b, a}
    input  logic signed [COORD_WIDTH-1:0]  px,
    input  logic signed [COORD_WIDTH-1:0]  py,
    input  logic signed [COORD_WIDTH-1:0]  pz,
    input  crpt_pkg::evl_tag_t             tag_in,
    output crpt_pkg::evl_res_t             res_out
);
    import crpt_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = 2 * CW;

    logic signed [CW-1:0]       a_in, b_in, c_in;
    logic signed [OFFSET_W-1:0] d_in;

    logic signed [PW-1:0]       pa_reg, pb_reg, pc_reg;
    logic signed [OFFSET_W-1:0] d1_reg;
    logic signed [SUM_W-1:0]    s1_reg, s2_reg, sum_reg;
    evl_tag_t                   tag1_reg, tag2_reg, tag3_reg;

    assign a_in = plane_in[0 +: CW];
    assign b_in = plane_in[CW +: CW];
    assign c_in = plane_in[2*CW +: CW];
    assign d_in = plane_in[3*CW +: OFFSET_W];

    // tags carry the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg  <= a_in * px;
        pb_reg  <= b_in * py;
        pc_reg  <= c_in * pz;
        d1_reg  <= d_in;
        s1_reg  <= SUM_W'(pa_reg) + SUM_W'(pb_reg);
        s2_reg  <= SUM_W'(pc_reg) + SUM_W'(d1_reg);
        sum_reg <= s1_reg + s2_reg;
    end

    assign res_out.valid  = tag3_reg.valid;
    assign res_out.used   = tag3_reg.used;
    assign res_out.last   = tag3_reg.last;
    assign res_out.nonpos = sum_reg[SUM_W-1] | (sum_reg == '0);
    assign res_out.nonneg = ~sum_reg[SUM_W-1];

endmodule

>>> src/crpt_checker.sv
// Port-level checker for convex_region_point_test_top, attached by bind.
// Depends on crpt_pkg and convex_region_point_test_top_assert.svh.
`include "convex_region_point_test_top_assert.svh"

module crpt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [crpt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);
    import crpt_pkg::*;

    // stalled result beat holds
    `CRPT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat dropped or changed under stall")

    // a taken load is acknowledged on the next cycle with inside_res clear
    `CRPT_ASSERT_NEXT(a_load_ack, clk, rst_n, s_tvalid && s_tready && (s_tuser == CMD_LOAD), m_tvalid && (m_tuser == KIND_LOAD) && (m_tdata == '0), "load not acknowledged next cycle")

    // a taken test closes the input as the ring starts to rotate
    `CRPT_ASSERT_NEXT(a_test_busy, clk, rst_n, s_tvalid && s_tready && (s_tuser == CMD_TEST), !s_tready, "input reopened during a test")

    // input never open while a result is stalled
    `CRPT_ASSERT_NOW(a_no_accept_stalled, clk, rst_n, m_tvalid && !m_tready, !s_tready, "input open while result stalled")

endmodule

bind convex_region_point_test_top crpt_checker u_crpt_checker (.*);
